### hdl/npgl_pkg.sv
// Shared types and codes for the nearest map point grip lookup.
`timescale 1ns / 1ps
package npgl_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned GRIP_W  = 16;
  localparam int unsigned MAG_W   = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned DIST_W  = SQ_W + 2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [GRIP_W-1:0] SCALE_RESET = 16'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SCALE,
    ST_DONE
  } npgl_state_t;

  typedef struct packed {
    logic [GRIP_W-1:0]  grip;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } npgl_point_t;

  typedef struct packed {
    logic vld;
    logic first;
  } npgl_tag_t;

endpackage

### hdl/npgl_dist.sv
// Four-stage squared distance unit with running nearest-point tracking.
`timescale 1ns / 1ps
module npgl_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  npgl_pkg::npgl_tag_t          tag_i,
  input  npgl_pkg::npgl_point_t        pt_i,
  input  npgl_pkg::npgl_point_t        query_i,
  output logic                         busy,
  output logic [npgl_pkg::GRIP_W-1:0]  best_grip
);
  import npgl_pkg::*;

  npgl_tag_t         tag1_r, tag2_r, tag3_r;
  logic [GRIP_W-1:0] grip1_r, grip2_r, grip3_r;
  logic [MAG_W-1:0]  mx_r, my_r, mz_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] best_d_r;
  logic [GRIP_W-1:0] best_grip_r;

  logic [MAG_W-1:0]  mx_nxt, my_nxt, mz_nxt;
  logic [DIST_W-1:0] dist_nxt;
  logic              take;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [MAG_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
  endfunction

  always_comb begin
    mx_nxt   = abs_diff(pt_i.x, query_i.x);
    my_nxt   = abs_diff(pt_i.y, query_i.y);
    mz_nxt   = abs_diff(pt_i.z, query_i.z);
    dist_nxt = DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
    take     = tag3_r.vld && (tag3_r.first || (dist_r < best_d_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    mz_r    <= mz_nxt;
    grip1_r <= pt_i.grip;
    sx_r    <= mx_r * mx_r;
    sy_r    <= my_r * my_r;
    sz_r    <= mz_r * mz_r;
    grip2_r <= grip1_r;
    dist_r  <= dist_nxt;
    grip3_r <= grip2_r;
    if (take) begin
      best_d_r    <= dist_r;
      best_grip_r <= grip3_r;
    end
  end

  assign busy      = tag1_r.vld || tag2_r.vld || tag3_r.vld;
  assign best_grip = best_grip_r;

endmodule

### hdl/nearest_point_grip_lookup.sv
// Nearest map point grip lookup: point table, scan sequencer and result register.
`timescale 1ns / 1ps
// A load request appends one map point to a table of MAX_POINTS entries; a
// load into a full table is dropped with status 1. A query request streams the
// stored points one per cycle out of the single read port of the point table
// into a four-stage squared-distance pipeline; a query on an empty table returns
// status 2. The returned grip is the nearest point's grip times grip_scale in
// Q2.14, saturated to 16 bits; the first point wins a tie. in_tready is high
// only between requests, but a new request is taken while the previous result
// still waits on the output side.
module nearest_point_grip_lookup #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // pos_x, pos_y, pos_z, point_grip
  input  logic [0:0]   in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // scaled_grip
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data // grip_scale
);
  import npgl_pkg::*;

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  npgl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [GRIP_W-1:0] scale_r;
  npgl_point_t       query_r;
  logic [GRIP_W-1:0] res_grip_r, res_grip_nxt;
  logic [1:0]        res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [GRIP_W-1:0] out_grip_r;
  logic [1:0]        out_stat_r;

  npgl_point_t       mem [0:MAX_POINTS-1];
  npgl_point_t       rd_pt_r;
  npgl_tag_t         rd_tag_r, rd_tag_nxt;

  npgl_point_t       in_pt;
  logic              in_acc;
  logic              full;
  logic              last_idx;
  logic              mem_we;
  logic              out_load;
  logic              dist_busy;
  logic [GRIP_W-1:0] best_grip;
  logic [31:0]       prod;

  assign in_pt    = npgl_point_t'(in_tdata);
  assign in_acc   = in_tvalid && in_tready;
  assign full     = (count_r == CNT_W'(MAX_POINTS));
  assign last_idx = (idx_r == (count_r - CNT_W'(1)));
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign prod     = 32'(best_grip) * 32'(scale_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if ((in_tuser[0] == FUNC_QUERY) && (count_r != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_tag_r.vld && !dist_busy) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_grip_nxt   = res_grip_r;
    res_stat_nxt   = res_stat_r;
    rd_tag_nxt     = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        idx_nxt   = '0;
        if (in_tvalid) begin
          res_grip_nxt = '0;
          if (in_tuser[0] == FUNC_LOAD) begin
            if (full) begin
              res_stat_nxt = STAT_FULL;
            end else begin
              res_stat_nxt = STAT_OK;
              mem_we       = 1'b1;
              count_nxt    = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            res_stat_nxt = STAT_EMPTY;
          end else begin
            res_stat_nxt = STAT_OK;
          end
        end
      end
      ST_SCAN: begin
        rd_tag_nxt.vld   = 1'b1;
        rd_tag_nxt.first = (idx_r == '0);
        idx_nxt          = idx_r + CNT_W'(1);
      end
      ST_SCALE: begin
        res_grip_nxt = (|prod[31:30]) ? {GRIP_W{1'b1}} : prod[29:14];
        res_stat_nxt = STAT_OK;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      scale_r     <= SCALE_RESET;
      rd_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rd_tag_r    <= rd_tag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_grip_r <= res_grip_nxt;
    res_stat_r <= res_stat_nxt;
    if (in_acc) begin
      query_r <= in_pt;
    end
    if (out_load) begin
      out_grip_r <= res_grip_r;
      out_stat_r <= res_stat_r;
    end
  end

  // point table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= in_pt;
    end
    rd_pt_r <= mem[idx_r[IDX_W-1:0]];
  end

  npgl_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (rd_tag_r),
    .pt_i      (rd_pt_r),
    .query_i   (query_r),
    .busy      (dist_busy),
    .best_grip (best_grip)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_grip_r;
  assign out_tuser  = out_stat_r;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table size");

  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser[0] == FUNC_LOAD) && full |=> $stable(count_r))
    else $error("load into full table changed count");

  a_scan_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r < count_r))
    else $error("scan index beyond stored points");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> (out_tdata == '0))
    else $error("error result carries nonzero grip");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the nearest map point grip lookup with a scoreboard.
module tb_top;
  import npgl_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [1:0]        status;
    logic [GRIP_W-1:0] grip;
  } grip_result_t;

  class grip_scoreboard;
    logic signed [COORD_W-1:0] x_store [TABLE_DEPTH];
    logic signed [COORD_W-1:0] y_store [TABLE_DEPTH];
    logic signed [COORD_W-1:0] z_store [TABLE_DEPTH];
    logic [GRIP_W-1:0]         grip_store [TABLE_DEPTH];
    int unsigned               count;
    logic [GRIP_W-1:0]         scale;
    grip_result_t              expected_results [$];
    int unsigned               errors;

    function new();
      count  = 0;
      scale  = SCALE_RESET;
      errors = 0;
    endfunction

    function grip_result_t predict_nearest_grip(input logic func,
                                                input logic signed [COORD_W-1:0] qx,
                                                input logic signed [COORD_W-1:0] qy,
                                                input logic signed [COORD_W-1:0] qz,
                                                input logic [GRIP_W-1:0] g);
      grip_result_t r;
      longint       dx, dy, dz, d, best_d;
      int unsigned  best;
      int unsigned  prod;
      r.grip   = '0;
      r.status = STAT_OK;
      best     = 0;
      best_d   = 0;
      if (func == FUNC_LOAD) begin
        if (count < TABLE_DEPTH) begin
          x_store[count]    = qx;
          y_store[count]    = qy;
          z_store[count]    = qz;
          grip_store[count] = g;
          count++;
        end else begin
          r.status = STAT_FULL;
        end
      end else if (count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        for (int unsigned i = 0; i < count; i++) begin
          dx = longint'(x_store[i]) - longint'(qx);
          dy = longint'(y_store[i]) - longint'(qy);
          dz = longint'(z_store[i]) - longint'(qz);
          d  = dx * dx + dy * dy + dz * dz;
          if (i == 0 || d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
        prod   = 32'(grip_store[best]) * 32'(scale);
        prod   = prod >> 14;
        r.grip = (prod > 65535) ? 16'hFFFF : prod[15:0];
      end
      return r;
    endfunction

    function void note_request(input logic func,
                               input logic signed [COORD_W-1:0] qx,
                               input logic signed [COORD_W-1:0] qy,
                               input logic signed [COORD_W-1:0] qz,
                               input logic [GRIP_W-1:0] g);
      grip_result_t want;
      want = predict_nearest_grip(func, qx, qy, qz, g);
      expected_results.insert(expected_results.size(), want);
    endfunction

    function void check_result(input logic [GRIP_W-1:0] grip, input logic [1:0] status);
      grip_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual grip %0d status %0d",
                 $time, grip, status);
        return;
      end
      want = expected_results.pop_front();
      if (grip !== want.grip) begin
        errors++;
        $display("%0t: scaled_grip mismatch, expected %0d, actual %0d",
                 $time, want.grip, grip);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, status);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [87:0]         in_tdata    = '0;  // pos_x, pos_y, pos_z, point_grip
  logic [0:0]          in_tuser    = '0;  // func
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [15:0]         out_tdata;         // scaled_grip
  logic [1:0]          out_tuser;         // status
  logic                cfg_wr_en   = 1'b0;
  logic [15:0]         cfg_wr_data = '0;  // grip_scale

  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    items_sent     = 0;
  int unsigned    cycle_count    = 0;
  grip_scoreboard sb             = new();

  nearest_point_grip_lookup #(
    .MAX_POINTS (TABLE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_point_grip_lookup test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
    end
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] jitter(input logic [COORD_W-1:0] c,
                                                 input int unsigned span);
    return c + 24'($urandom_range(2 * span) - span);
  endfunction

  function automatic logic [GRIP_W-1:0] rand_grip();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h4000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_request(input logic func, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                              input logic [GRIP_W-1:0] g);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {g, z, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_request(func, x, y, z, g);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_scale(input logic [GRIP_W-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.scale = v;
  endtask

  task automatic send_load();
    int unsigned         k;
    logic [COORD_W-1:0]  x, y, z;
    x = rand_coord();
    y = rand_coord();
    z = rand_coord();
    if (sb.count != 0) begin
      k = $urandom_range(sb.count - 1);
      case ($urandom_range(3))
        0: begin
          x = sb.x_store[k];
          y = sb.y_store[k];
          z = sb.z_store[k];
        end
        1: begin
          x = jitter(sb.x_store[k], 64);
          y = jitter(sb.y_store[k], 64);
          z = jitter(sb.z_store[k], 64);
        end
        default: ;
      endcase
    end
    send_request(FUNC_LOAD, x, y, z, rand_grip());
  endtask

  task automatic send_wheel_set();
    int unsigned        k, span;
    logic [COORD_W-1:0] bx, by, bz;
    bx   = rand_coord();
    by   = rand_coord();
    bz   = rand_coord();
    span = ($urandom_range(4) == 0) ? 0 : (1 << $urandom_range(12));
    if (sb.count != 0 && $urandom_range(3) != 0) begin
      k  = $urandom_range(sb.count - 1);
      bx = sb.x_store[k];
      by = sb.y_store[k];
      bz = sb.z_store[k];
    end
    repeat (4) begin
      send_request(FUNC_QUERY, jitter(bx, span), jitter(by, span), jitter(bz, span),
                   16'($urandom()));
    end
  endtask

  initial begin
    logic [GRIP_W-1:0] phase_scale [PHASE_COUNT];
    int unsigned       directed_items, phase_end, load_pct;
    phase_scale = '{16'd16384, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'h0, 16'h0, 16'h3FFF};
    phase_scale[5] = 16'($urandom());
    phase_scale[6] = 16'($urandom());
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(FUNC_QUERY, 24'h000000, 24'h000000, 24'h000000, 16'hFFFF);
    send_request(FUNC_LOAD,  24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
    send_request(FUNC_LOAD,  24'h800000, 24'h800000, 24'h800000, 16'h0000);
    send_request(FUNC_LOAD,  24'h000000, 24'h000000, 24'h000000, 16'h4000);
    send_request(FUNC_LOAD,  24'h000000, 24'h000000, 24'h000000, 16'h3039);
    send_request(FUNC_LOAD,  24'hFFFFFF, 24'h000001, 24'h7FFFFF, 16'h0001);
    send_request(FUNC_QUERY, 24'h000000, 24'h000000, 24'h000000, 16'h0000);
    send_request(FUNC_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h1234);
    send_request(FUNC_QUERY, 24'h800000, 24'h800000, 24'h800000, 16'hFFFF);
    send_request(FUNC_QUERY, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h0000);
    send_request(FUNC_QUERY, 24'h000001, 24'h000000, 24'h000000, 16'h0000);
    send_request(FUNC_QUERY, 24'hFFFFFF, 24'h000001, 24'h7FFFFF, 16'h0000);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    send_request(FUNC_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0000);
    directed_items = items_sent;

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      write_scale(phase_scale[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      phase_end = directed_items + (p + 1) * (ITEM_TARGET - directed_items) / PHASE_COUNT;
      while (items_sent < phase_end) begin
        load_pct = (sb.count < TABLE_DEPTH) ? 70 : 15;
        if ($urandom_range(99) < load_pct) begin
          send_load();
        end else begin
          send_wheel_set();
        end
        if ($urandom_range(199) == 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("nearest_point_grip_lookup test passed");
    end else begin
      $display("nearest_point_grip_lookup test failed");
    end
    $finish;
  end

endmodule
